[rtl/bdpe_pkg.sv]
// Shared constants and types for the button debounce / press event block.
// No dependencies; imported by the top level.
`default_nettype none

package bdpe_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int PIN_BITS    = 6;
    localparam int MAX_RESULTS = 12;

    localparam int IDX_W    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int KEY_W    = 3;
    localparam int KIND_W   = 3;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 4;
    localparam int MS_W     = 16;
    localparam int RES_W    = $clog2(MAX_RESULTS + 1);

    localparam int S_DATA_W = 40;       // pins + now_ms, padded to bytes
    localparam int M_DATA_W = 8;        // key, padded to bytes
    localparam int M_USER_W = KIND_W;   // event kind

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 2'd3;

    localparam logic             RST_ACTIVE_LOW = 1'b1;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE   = 4'd3;
    localparam logic [MS_W-1:0]  RST_LONG_MS    = 16'd350;
    localparam logic [MS_W-1:0]  RST_REPEAT_MS  = 16'd100;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 3'd0,
        KIND_SHORT   = 3'd1,
        KIND_LONG    = 3'd2,
        KIND_REPEAT  = 3'd3,
        KIND_RELEASE = 3'd4
    } t_kind;

    typedef logic [NUM_BUTTONS-1:0] t_btn_vec;

    // per-button state word held in the state RAM
    typedef struct packed {
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] repeat_time;
        logic              long_done;
        logic              stable;
        logic [CNT_W-1:0]  agree;
        logic              raw;
    } t_btn_entry;

    localparam t_btn_entry ENTRY_RST = '0;

endpackage

`default_nettype wire

[rtl/bdpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bdpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/button_debounce_press_events.sv]
// Button debouncer with press / short / long / repeat / release events.
// Depends on bdpe_pkg and bdpe_ram.
//
// Usage:
//  - Slave stream: one beat per poll. tdata[5:0] raw pin levels (bit i is
//    button i), tdata[37:6] millisecond timestamp, rest zero.
//  - Master stream: one beat per event. tdata[2:0] button index,
//    tuser event kind (press, short, long, repeat, release);
//    tlast marks the final event of a poll. A poll with no events
//    gives no beat.
//  - Config port: write enable, register index, data; write only while idle.
//  - Per-button state lives in a small RAM; each button is one
//    read-modify-write: the registered read, the write-back in S_CALC,
//    then S_EV hands the button's events, in order, to the output.
//  - Poll cost is set by the one RAM lookup per button and one event per
//    cycle into the output register, while the master side does not stall.
//  - The last event is held back one slot until the poll's end is known,
//    so tlast can be set on it.
//  - A stalled master side holds the sequencer at the next event; nothing
//    is dropped. A new poll is taken once the previous poll's last event
//    sits in the output register.
//  - Reset clears the per-entry valid bits at once: no clearing pass.
`default_nettype none

module button_debounce_press_events (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // poll input
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [bdpe_pkg::S_DATA_W-1:0]     i_s_axis_tdata,  // pin_levels, now_ms
    // event output
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic      [bdpe_pkg::M_DATA_W-1:0]     o_m_axis_tdata,  // event_key
    output logic      [bdpe_pkg::M_USER_W-1:0]     o_m_axis_tuser,  // event_kind
    output logic                                   o_m_axis_tlast,  // last_event
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [bdpe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bdpe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import bdpe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_EV, S_FLUSH} t_state;

    t_state r_state;

    // config registers
    logic             r_active_low;
    logic [CNT_W-1:0] r_debounce;
    logic [MS_W-1:0]  r_long_ms;
    logic [MS_W-1:0]  r_repeat_ms;

    // latched poll
    logic [PIN_BITS-1:0] r_pins;
    logic [TIME_W-1:0]   r_now;
    logic [IDX_W-1:0]    r_idx;
    logic [RES_W-1:0]    r_count;
    t_btn_vec            r_valid;

    // events of the current button, in order
    logic [1:0] r_ev_v;
    t_kind      r_ev_k0;
    t_kind      r_ev_k1;

    // held-back event (tlast unknown yet)
    logic             r_pend_v;
    t_kind            r_pend_kind;
    logic [KEY_W-1:0] r_pend_key;

    // output register
    logic             r_out_v;
    t_kind            r_out_kind;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_last;

    // RAM ports
    logic             w_ram_re;
    logic [IDX_W-1:0] w_ram_raddr;
    t_btn_entry       w_ram_rdata;

    // datapath
    t_btn_entry  w_old;
    t_btn_entry  n_entry;
    t_btn_vec    w_pins_ext;
    logic        w_level;
    logic        w_pressed;
    logic        w_accepted;
    logic [TIME_W-1:0] w_held;
    logic [TIME_W-1:0] w_since;
    logic        n_ev0_v;
    logic        n_ev1_v;
    t_kind       n_ev0_k;
    t_kind       n_ev1_k;

    // event issue
    logic w_s_fire;
    logic w_out_free;
    logic w_drop;
    logic w_push_ok;
    logic w_fire;
    logic w_btn_done;
    logic w_last_btn;

    assign w_s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_v || i_m_axis_tready;
    assign w_drop     = (r_count >= RES_W'(MAX_RESULTS));
    assign w_push_ok  = w_drop || !r_pend_v || w_out_free;
    assign w_fire     = r_ev_v[0] && w_push_ok;
    assign w_btn_done = !r_ev_v[0] || (w_push_ok && !r_ev_v[1]);
    assign w_last_btn = (r_idx == IDX_W'(NUM_BUTTONS - 1));

    // read button 0 on accept, next button when the current one is done;
    // write-back is in S_CALC, so a read never meets a write to its entry
    assign w_ram_re    = w_s_fire ||
                         ((r_state == S_EV) && w_btn_done && !w_last_btn);
    assign w_ram_raddr = (r_state == S_IDLE) ? '0 : r_idx + IDX_W'(1);

    bdpe_ram #(
        .WIDTH ($bits(t_btn_entry)),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_idx),
        .i_wdata (n_entry),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // debounce and event decision for button r_idx
    always_comb begin
        w_old      = r_valid[r_idx] ? w_ram_rdata : ENTRY_RST;
        n_entry    = w_old;
        w_pins_ext = t_btn_vec'(r_pins);   // missing pins read as 0
        w_level    = w_pins_ext[r_idx];
        w_pressed  = r_active_low ? !w_level : w_level;
        n_ev0_v    = 1'b0;
        n_ev1_v    = 1'b0;
        n_ev0_k    = KIND_PRESS;
        n_ev1_k    = KIND_RELEASE;
        w_held     = r_now - w_old.press_time;
        w_since    = r_now - w_old.repeat_time;

        if (w_pressed != w_old.raw) begin
            n_entry.raw   = w_pressed;
            n_entry.agree = '0;
        end else if (w_old.agree < r_debounce) begin
            n_entry.agree = w_old.agree + CNT_W'(1);
        end

        w_accepted = (n_entry.agree >= r_debounce) ? n_entry.raw : w_old.stable;

        if (w_accepted != w_old.stable) begin
            n_entry.stable = w_accepted;
            if (w_accepted) begin
                n_entry.press_time = r_now;
                n_entry.long_done  = 1'b0;
                n_ev0_v = 1'b1;
                n_ev0_k = KIND_PRESS;
            end else if (!w_old.long_done) begin
                n_ev0_v = 1'b1;
                n_ev0_k = KIND_SHORT;
                n_ev1_v = 1'b1;
                n_ev1_k = KIND_RELEASE;
            end else begin
                n_ev0_v = 1'b1;
                n_ev0_k = KIND_RELEASE;
            end
        end else if (w_old.stable) begin
            if (!w_old.long_done && (w_held >= TIME_W'(r_long_ms))) begin
                n_entry.long_done   = 1'b1;
                n_entry.repeat_time = r_now;
                n_ev0_v = 1'b1;
                n_ev0_k = KIND_LONG;
            end else if (w_old.long_done && (w_since >= TIME_W'(r_repeat_ms))) begin
                n_entry.repeat_time = r_now;
                n_ev0_v = 1'b1;
                n_ev0_k = KIND_REPEAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active_low <= RST_ACTIVE_LOW;
            r_debounce   <= RST_DEBOUNCE;
            r_long_ms    <= RST_LONG_MS;
            r_repeat_ms  <= RST_REPEAT_MS;
            r_valid      <= '0;
            r_ev_v       <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_count      <= '0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                    CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[CNT_W-1:0];
                    CFG_LONG_PRESS: r_long_ms    <= i_cfg_data[MS_W-1:0];
                    CFG_REPEAT:     r_repeat_ms  <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_v && i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_pins  <= i_s_axis_tdata[PIN_BITS-1:0];
                        r_now   <= i_s_axis_tdata[PIN_BITS +: TIME_W];
                        r_idx   <= '0;
                        r_count <= '0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_valid[r_idx] <= 1'b1;
                    r_ev_v  <= {n_ev1_v, n_ev0_v};
                    r_ev_k0 <= n_ev0_k;
                    r_ev_k1 <= n_ev1_k;
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (w_fire) begin
                        if (!w_drop) begin
                            if (r_pend_v) begin
                                r_out_v    <= 1'b1;
                                r_out_kind <= r_pend_kind;
                                r_out_key  <= r_pend_key;
                                r_out_last <= 1'b0;
                            end
                            r_pend_v    <= 1'b1;
                            r_pend_kind <= r_ev_k0;
                            r_pend_key  <= KEY_W'(r_idx);
                            r_count     <= r_count + RES_W'(1);
                        end
                        r_ev_v  <= {1'b0, r_ev_v[1]};
                        r_ev_k0 <= r_ev_k1;
                    end
                    if (w_btn_done) begin
                        if (w_last_btn) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_CALC;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_kind <= r_pend_kind;
                        r_out_key  <= r_pend_key;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(M_DATA_W - KEY_W){1'b0}}, r_out_key};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // a poll never ends with an event still held back
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held-back event left over at poll end");

    // state word is always looked up the cycle before it is used
    a_calc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> $past(w_ram_re))
        else $error("button processed without a RAM read");

    // second event only ever queued behind a first
    a_ev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_v[1] |-> r_ev_v[0])
        else $error("event slots out of order");

    // never overwrite an output beat that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_axis_tready) |=> (r_out_v && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast)))
        else $error("output beat overwritten while stalled");

    // per-poll event count stays within the limit
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= RES_W'(MAX_RESULTS)))
        else $error("too many events in one poll");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for button_debounce_press_events.
// Depends on bdpe_pkg and the block's RTL. Drives polls and config writes, checks each
// event beat against a built-in predictor of the debounce and press-event rules.
`default_nettype none

module testbench;
    import bdpe_pkg::*;

    // cycles with no beat on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // idle wait after the last event: a poll with no events still occupies the sequencer
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [PIN_BITS-1:0] pins;
        logic [TIME_W-1:0]   now_ms;
    } t_poll;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_kind            kind;
        logic             last;
    } t_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_DATA_W-1:0]   i_s_axis_tdata = '0;   // pin_levels, now_ms
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;        // event_key
    logic [M_USER_W-1:0]   o_m_axis_tuser;        // event_kind
    logic                  o_m_axis_tlast;        // last_event
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    button_debounce_press_events u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_poll  pending_polls[$];      // polls waiting to be driven
    t_event expected_events[$];    // predicted beats, oldest first
    int     polls_queued = 0;
    int     polls_taken = 0;
    int     mismatches = 0;
    int     quiet_cycles = 0;
    int     send_idle_pct = 0;     // chance per cycle the sender holds off
    int     recv_stall_pct = 0;    // chance per cycle the receiver drops tready

    // predictor's copy of the config registers
    logic             cfg_active_low = RST_ACTIVE_LOW;
    logic [CNT_W-1:0] cfg_debounce = RST_DEBOUNCE;
    logic [MS_W-1:0]  cfg_long_ms = RST_LONG_MS;
    logic [MS_W-1:0]  cfg_repeat_ms = RST_REPEAT_MS;

    // predictor's copy of the per-button state
    logic              raw_seen[NUM_BUTTONS];
    logic [CNT_W-1:0]  agree_cnt[NUM_BUTTONS];
    logic              stable_on[NUM_BUTTONS];
    logic              long_hit[NUM_BUTTONS];
    logic [TIME_W-1:0] press_at[NUM_BUTTONS];
    logic [TIME_W-1:0] repeat_at[NUM_BUTTONS];

    // stimulus generator state: intended button positions and the running clock
    t_btn_vec          gen_held = '0;
    logic [TIME_W-1:0] gen_now = '0;

    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            raw_seen[b]  = 1'b0;
            agree_cnt[b] = '0;
            stable_on[b] = 1'b0;
            long_hit[b]  = 1'b0;
            press_at[b]  = '0;
            repeat_at[b] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Event predictor
    // ------------------------------------------------------------------
    task automatic note_event(input int b, input t_kind k);
        t_event ev;
        ev.key  = b[KEY_W-1:0];
        ev.kind = k;
        ev.last = 1'b0;
        expected_events.push_back(ev);
    endtask

    // One poll: walk the buttons in index order, at most two events each.
    task automatic predict_events(input logic [PIN_BITS-1:0] pins,
                                  input logic [TIME_W-1:0] now);
        int                first_new;
        logic              pressed;
        logic              accepted;
        logic [TIME_W-1:0] held_ms;
        logic [TIME_W-1:0] since_rep;
        first_new = expected_events.size();
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            pressed = cfg_active_low ? ~pins[b] : pins[b];
            // a change of raw reading restarts the agreement count; otherwise
            // count up to the threshold (a larger leftover count is kept)
            if (pressed != raw_seen[b]) begin
                raw_seen[b]  = pressed;
                agree_cnt[b] = '0;
            end else if (agree_cnt[b] < cfg_debounce) begin
                agree_cnt[b] = agree_cnt[b] + 1'b1;
            end
            accepted = (agree_cnt[b] >= cfg_debounce) ? raw_seen[b] : stable_on[b];
            if (accepted != stable_on[b]) begin
                stable_on[b] = accepted;
                if (accepted) begin
                    press_at[b] = now;
                    long_hit[b] = 1'b0;
                    note_event(b, KIND_PRESS);
                end else begin
                    // short only when the hold never reached long
                    if (!long_hit[b])
                        note_event(b, KIND_SHORT);
                    note_event(b, KIND_RELEASE);
                end
            end else if (stable_on[b]) begin
                held_ms   = now - press_at[b];        // wraps mod 2^32
                since_rep = now - repeat_at[b];
                if (!long_hit[b] && held_ms >= TIME_W'(cfg_long_ms)) begin
                    long_hit[b]  = 1'b1;
                    repeat_at[b] = now;
                    note_event(b, KIND_LONG);
                end else if (long_hit[b] && since_rep >= TIME_W'(cfg_repeat_ms)) begin
                    repeat_at[b] = now;
                    note_event(b, KIND_REPEAT);
                end
            end
        end
        // tlast rides on the final event of the poll
        if (expected_events.size() > first_new)
            expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Poll driver: feeds pending_polls onto the slave stream, predicting
    // on every accepted beat. tvalid is assigned once per edge.
    // ------------------------------------------------------------------
    t_poll next_poll;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_events(i_s_axis_tdata[PIN_BITS-1:0],
                               i_s_axis_tdata[PIN_BITS +: TIME_W]);
                polls_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_poll = pending_polls.pop_front();
                    i_s_axis_tdata  <= S_DATA_W'({next_poll.now_ms, next_poll.pins});
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Event monitor: random backpressure, in-order field compare.
    // ------------------------------------------------------------------
    t_event want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event beat: key %0d kind %0d last %0d",
                             $time, o_m_axis_tdata[KEY_W-1:0], o_m_axis_tuser,
                             o_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_m_axis_tdata[KEY_W-1:0] !== want.key ||
                        o_m_axis_tuser !== want.kind ||
                        o_m_axis_tlast !== want.last) begin
                        $display("%0t: expected key/kind/last %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.key, want.kind, want.last,
                                 o_m_axis_tdata[KEY_W-1:0], o_m_axis_tuser,
                                 o_m_axis_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either stream means a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_poll(input logic [PIN_BITS-1:0] pins, input logic [TIME_W-1:0] now);
        t_poll p;
        p.pins   = pins;
        p.now_ms = now;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    // Only called while the block is idle, so the predictor can follow at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE_LOW: cfg_active_low = val[0];
            CFG_DEBOUNCE:   cfg_debounce   = val[CNT_W-1:0];
            CFG_LONG_PRESS: cfg_long_ms    = val[MS_W-1:0];
            CFG_REPEAT:     cfg_repeat_ms  = val[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic al, input logic [CNT_W-1:0] db,
                              input logic [MS_W-1:0] long_ms, input logic [MS_W-1:0] rep_ms);
        write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(al));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(db));
        write_reg(CFG_LONG_PRESS, long_ms);
        write_reg(CFG_REPEAT, rep_ms);
    endtask

    // Hold off until every poll is taken and every event has arrived, then
    // let the sequencer finish any event-less poll still in progress.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (polls_taken != polls_queued || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly realistic button activity (slow toggles, occasional bounce),
    // with a few fully random polls and time jumps mixed in.
    task automatic gen_polls(input int n, input int step_max,
                             input int toggle_pct, input int glitch_pct);
        t_btn_vec            pressed;
        logic [PIN_BITS-1:0] pins;
        for (int k = 0; k < n; k++) begin
            for (int b = 0; b < NUM_BUTTONS; b++)
                if ($urandom_range(99) < toggle_pct)
                    gen_held[b] = ~gen_held[b];
            pressed = gen_held;
            for (int b = 0; b < NUM_BUTTONS; b++)
                if ($urandom_range(99) < glitch_pct)
                    pressed[b] = ~pressed[b];
            pins = cfg_active_low ? ~pressed : pressed;
            if ($urandom_range(99) < 8) begin
                pins    = PIN_BITS'($urandom);
                gen_now = $urandom;
            end else begin
                gen_now = gen_now + TIME_W'($urandom_range(step_max));
            end
            push_poll(pins, gen_now);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset values written explicitly, no idling.
        set_config(1'b1, 4'd3, 16'd350, 16'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_poll(6'h3F, 32'h0000_0000);              // all released, time zero
        for (int k = 0; k < 4; k++)                   // press all, debounced on 4th
            push_poll(6'h00, 32'hFFFF_FF00 + 10 * k);
        push_poll(6'h00, 32'h0000_007B);              // held 349 ms across the wrap
        push_poll(6'h00, 32'h0000_007C);              // 350 ms: long on every button
        push_poll(6'h00, 32'h0000_00DF);              // 99 ms since long: nothing
        push_poll(6'h00, 32'h0000_00E0);              // 100 ms: repeat
        push_poll(6'h00, 32'hFFFF_FFFF);              // huge wrapped gap: repeat
        for (int k = 0; k < 4; k++)                   // release after long: no short
            push_poll(6'h3F, 32'h0000_1000 + k);
        for (int k = 0; k < 4; k++)                   // quick press of all
            push_poll(6'h00, 32'h0000_2000 + k);
        for (int k = 0; k < 4; k++)                   // short + release x6 = 12 beats
            push_poll(6'h3F, 32'h0000_2010 + k);
        wait_quiet();

        // Slowest debounce, longest intervals, time wrapping; sender mostly idle.
        set_config(1'b1, 4'd15, 16'hFFFF, 16'hFFFF);
        send_idle_pct  = 82;
        recv_stall_pct = 0;
        gen_now = 32'hFFFF_0000;
        gen_polls(35, 9000, 2, 1);
        wait_quiet();

        // Debounce lowered under the saturated counts, active-high pins,
        // zero long and repeat; receiver mostly stalled.
        set_config(1'b0, 4'd2, 16'd0, 16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        gen_polls(35, 30, 10, 5);
        wait_quiet();

        // No debounce at all, short intervals, light idling on both sides.
        set_config(1'b1, 4'd0, 16'd40, 16'd15);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        gen_polls(35, 20, 8, 10);
        wait_quiet();

        // Moderate settings, full rate.
        set_config(1'b1, 4'd4, 16'd120, 16'd30);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_polls(35, 25, 5, 4);
        wait_quiet();

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
